@@ sv/fwnf_pkg.sv @@
package fwnf_pkg;

  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned IDX_W      = $clog2(DEC_DIGITS);

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  // 2^35 / 10 rounded up: exact quotient for any 32-bit dividend after >> 35.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] number;
    logic [3:0]  length;
    logic [2:0]  line;
    logic [4:0]  column;
  } item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [2:0] out_line;
    logic [4:0] out_column;
    logic       last;
  } result_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic sign;
    logic digit;
  } cmd_t;

  typedef struct packed {
    logic item_skip;
    logic item_len_zero;
    logic signed_mode;
    logic len_zero;
    logic conv_last;
    logic emit_last;
  } stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] code;
    if (d < 4'd10) begin
      code = CH_ZERO + {3'b000, d};
    end else begin
      code = CH_A + {3'b000, d} - 7'd10;
    end
    return code;
  endfunction

endpackage

@@ sv/fwnf_ctrl.sv @@
module fwnf_ctrl
  import fwnf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start && !stat.item_skip) begin
          cmd.load   = 1'b1;
          state_next = stat.item_len_zero ? ST_SIGN : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (stat.conv_last) begin
          state_next = stat.signed_mode ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd.sign   = 1'b1;
        state_next = stat.len_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.digit = 1'b1;
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/fwnf_dp.sv @@
module fwnf_dp
  import fwnf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output stat_t   stat,
  output result_t result,
  output logic    strobe
);

  logic             hex_mode;
  logic             signed_mode;
  logic             neg;
  logic [31:0]      val;
  logic [3:0]       len;
  logic [2:0]       line;
  logic [4:0]       col;
  logic [IDX_W-1:0] k;
  logic [3:0]       digs [DEC_DIGITS];

  logic [3:0]  len_sat;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] val_next;
  logic [3:0]  dig_next;
  logic [IDX_W-1:0] rd_idx;

  // Saturate the digit count per mode.
  always_comb begin
    if (item.op == OP_HEX) begin
      len_sat = (item.length > 4'(HEX_DIGITS)) ? 4'(HEX_DIGITS) : item.length;
    end else begin
      len_sat = (item.length > 4'(DEC_DIGITS)) ? 4'(DEC_DIGITS) : item.length;
    end
  end

  // One digit per step: divide by ten through the reciprocal, or peel a nibble.
  assign prod = val * RECIP10;
  assign quo  = {3'b000, prod[63:35]};
  assign rem  = val - ((quo << 3) + (quo << 1));

  always_comb begin
    if (hex_mode) begin
      val_next = val >> 4;
      dig_next = val[3:0];
    end else begin
      val_next = quo;
      dig_next = rem[3:0];
    end
  end

  assign rd_idx = k - IDX_W'(1);

  assign stat.item_skip     = (item.op == OP_NONE) ||
                              ((item.length == 4'd0) && (item.op != OP_SDEC));
  assign stat.item_len_zero = (item.length == 4'd0);
  assign stat.signed_mode   = signed_mode;
  assign stat.len_zero      = (len == 4'd0);
  assign stat.conv_last     = (4'(k) == len - 4'd1);
  assign stat.emit_last     = (k == IDX_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_mode    <= (item.op == OP_HEX);
      signed_mode <= (item.op == OP_SDEC);
      neg         <= (item.op == OP_SDEC) && item.number[31];
      val         <= ((item.op == OP_SDEC) && item.number[31]) ? (32'd0 - item.number)
                                                               : item.number;
      len         <= len_sat;
      line        <= item.line;
      col         <= item.column;
      k           <= '0;
    end else if (cmd.conv) begin
      digs[k] <= dig_next;
      val     <= val_next;
      k       <= k + IDX_W'(1);
    end else if (cmd.sign) begin
      col <= col + 5'd1;
    end else if (cmd.digit) begin
      col <= col + 5'd1;
      k   <= rd_idx;
    end
  end

  // Output register: one character per strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.sign || cmd.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign) begin
      result.char_code  <= neg ? CH_MINUS : CH_PLUS;
      result.out_line   <= line;
      result.out_column <= col;
      result.last       <= (len == 4'd0);
    end else if (cmd.digit) begin
      result.char_code  <= digit_char(digs[rd_idx]);
      result.out_line   <= line;
      result.out_column <= col;
      result.last       <= (k == IDX_W'(1));
    end
  end

endmodule

@@ sv/fixed_width_number_formatter.sv @@
// Order: with n = saturated digit count, the first character follows the n
// conversion steps and then the output register.
// Busy covers the conversion steps, the sign (signed mode) and the digit emits; no
// new item is taken until idle. Decimal digits come from the shared divide-by-ten unit.
// Characters then come one per cycle; strobe marks each for exactly one cycle.
// Reset (rst, synchronous, active high) returns the controller to idle, no strobe.
module fixed_width_number_formatter
  import fwnf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  // Command and status between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: idle -> conversion steps -> sign (signed mode) -> digits.
  // A transfer whose op is undefined, or with zero digits outside signed
  // mode, leaves the block idle and produces nothing.
  fwnf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: latch the item, take the magnitude, peel digits least
  // significant first into a small digit store, then read them back most
  // significant first through the registered result port.
  fwnf_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

endmodule

@@ sv/fwnf_checker.sv @@
module fwnf_checker
  import fwnf_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  // Characters of one number come out without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a character run");

  // More characters pending means the block stays busy.
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("idle while characters pending");

  // Only digits, A-F and signs leave the block.
  a_code: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.char_code == CH_PLUS) || (result.char_code == CH_MINUS) ||
               ((result.char_code >= CH_ZERO) && (result.char_code <= 7'h39)) ||
               ((result.char_code >= CH_A) && (result.char_code <= 7'h46)))
    else $error("bad character code");

  // An accepted item with output to produce raises busy.
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.op != OP_NONE) &&
    ((item.length != 4'd0) || (item.op == OP_SDEC)) |=> busy)
    else $error("accepted item did not start");

  // An undefined op is dropped.
  a_skip: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.op == OP_NONE) |=> !busy)
    else $error("undefined op started work");

endmodule

bind fixed_width_number_formatter fwnf_checker u_fwnf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import fwnf_pkg::*;
();

  // Idle time allowed after the last expected character before the block is treated
  // as quiet: it covers the longest item's conversion steps, emits, sign and output stage.
  localparam int unsigned SETTLE_CYCLES  = 32;
  // Cycles with neither an input transfer nor a character before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Input items with a defined op, queued anew in each of the three idle phases.
  localparam int unsigned PHASE_ITEMS    = 63;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  item_t   pending_numbers[$];   // items waiting for the driver
  result_t expected_chars[$];    // characters predicted but not yet seen

  int unsigned sender_idle_pct = 32;
  logic        took_item = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned chars_checked = 0;
  int unsigned numbers_sent[4] = '{0, 0, 0, 0};

  fixed_width_number_formatter dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Work out the characters one number turns into and queue them in order.
  function automatic void predict_chars(input item_t num_in);
    logic [31:0] magnitude;
    logic [31:0] radix;
    logic [4:0]  digit_col;
    int unsigned digit_count;
    int unsigned digit_vals[DEC_DIGITS];
    int unsigned d;
    logic        negative;
    result_t     ch;

    if (num_in.op == OP_NONE) return;

    // Hex saturates at eight digits, decimal at ten.
    if (num_in.op == OP_HEX) begin
      radix = 32'd16;
      digit_count = (num_in.length > HEX_DIGITS) ? HEX_DIGITS : num_in.length;
    end else begin
      radix = 32'd10;
      digit_count = (num_in.length > DEC_DIGITS) ? DEC_DIGITS : num_in.length;
    end

    magnitude = num_in.number;
    digit_col = num_in.column;
    ch.out_line = num_in.line;

    // Signed mode: sign first at the start column, digits shift one column right.
    // The most negative value negates to itself, i.e. 2147483648 unsigned.
    if (num_in.op == OP_SDEC) begin
      negative = magnitude[31];
      if (negative) magnitude = -magnitude;
      ch.char_code  = negative ? CH_MINUS : CH_PLUS;
      ch.out_column = digit_col;
      ch.last       = (digit_count == 0);
      expected_chars.push_back(ch);
      digit_col = digit_col + 5'd1;
    end

    // Least significant first; anything above base^length just drops away.
    for (int unsigned i = 0; i < digit_count; i++) begin
      digit_vals[i] = magnitude % radix;
      magnitude = magnitude / radix;
    end

    for (int unsigned i = 0; i < digit_count; i++) begin
      d = digit_vals[digit_count - 1 - i];
      ch.char_code  = (d < 10) ? CH_ZERO + 7'(d) : CH_A + 7'(d - 10);
      ch.out_column = digit_col + 5'(i);   // wraps past 31 like the hardware
      ch.last       = (i + 1 == digit_count);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic item_t make_number(input logic [1:0] op, input logic [31:0] value,
                                        input logic [3:0] len, input logic [2:0] ln,
                                        input logic [4:0] col);
    item_t it;
    it.op     = op;
    it.number = value;
    it.length = len;
    it.line   = ln;
    it.column = col;
    return it;
  endfunction

  // Mostly in-range lines, columns and lengths, with a tail that reaches every bit.
  function automatic item_t random_number();
    item_t it;
    logic [31:0] edges[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    it.op = ($urandom_range(19, 0) == 0) ? OP_NONE : 2'($urandom_range(2, 0));
    case ($urandom_range(7, 0))
      0: it.number = $urandom_range(99, 0);
      1: it.number = edges[$urandom_range(3, 0)];
      2: it.number = -32'($urandom_range(999, 1));
      default: it.number = $urandom();
    endcase
    it.length = ($urandom_range(9, 0) < 8) ? 4'($urandom_range(10, 1))
                                           : 4'($urandom_range(15, 0));
    it.line   = ($urandom_range(9, 0) < 8) ? 3'($urandom_range(4, 1))
                                           : 3'($urandom_range(7, 0));
    it.column = ($urandom_range(9, 0) < 8) ? 5'($urandom_range(16, 1))
                                           : 5'($urandom_range(31, 0));
    return it;
  endfunction

  // Queue random numbers until enough of them have a defined op.
  task automatic queue_random_numbers(input int unsigned target);
    int unsigned useful;
    item_t it;
    useful = 0;
    while (useful < target) begin
      it = random_number();
      pending_numbers.push_back(it);
      if (it.op != OP_NONE) useful++;
    end
  endtask

  // Hold the sender until every queued number has been transferred and all its
  // characters have come out, then let the block settle. Ends on a rising edge so
  // the next refill of the queue never shares a time step with the driver.
  task automatic drain();
    while (pending_numbers.size() != 0 || start) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  // Driver: advance on the falling edge; keep start high until the transfer happens.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (pending_numbers.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        item  <= pending_numbers.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check characters and predict new ones on the rising edge.
  always @(posedge clk) begin
    result_t exp_ch;
    if (rst) begin
      took_item <= 1'b0;
    end else begin
      took_item <= start && !busy;

      // Check before predicting: a character never belongs to the number
      // transferred at the same edge.
      if (strobe) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("character with nothing expected: code %h line %0d column %0d last %0d",
                 result.char_code, result.out_line, result.out_column, result.last);
          error_count++;
        end else begin
          exp_ch = expected_chars.pop_front();
          if (result.char_code !== exp_ch.char_code) begin
            $error("char_code: expected %h, got %h", exp_ch.char_code, result.char_code);
            error_count++;
          end
          if (result.out_line !== exp_ch.out_line) begin
            $error("out_line: expected %0d, got %0d", exp_ch.out_line, result.out_line);
            error_count++;
          end
          if (result.out_column !== exp_ch.out_column) begin
            $error("out_column: expected %0d, got %0d", exp_ch.out_column, result.out_column);
            error_count++;
          end
          if (result.last !== exp_ch.last) begin
            $error("last: expected %0d, got %0d", exp_ch.last, result.last);
            error_count++;
          end
        end
      end

      if (start && !busy) begin
        predict_chars(item);
        numbers_sent[item.op]++;
      end

      // Watchdog: any transfer in either direction resets the count.
      if ((start && !busy) || strobe) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    // Directed part: field extremes, every mode, saturation, wrap and ignored items.
    pending_numbers.push_back(make_number(OP_UDEC, 32'd0,          4'd10, 3'd1, 5'd1));
    pending_numbers.push_back(make_number(OP_UDEC, 32'hFFFF_FFFF,  4'd10, 3'd4, 5'd16));
    pending_numbers.push_back(make_number(OP_UDEC, 32'd1234567890, 4'd4,  3'd2, 5'd5));
    pending_numbers.push_back(make_number(OP_UDEC, 32'hFFFF_FFFF,  4'd15, 3'd7, 5'd31));
    pending_numbers.push_back(make_number(OP_UDEC, 32'd42,         4'd0,  3'd1, 5'd1));
    pending_numbers.push_back(make_number(OP_UDEC, 32'd9,          4'd1,  3'd0, 5'd0));
    pending_numbers.push_back(make_number(OP_SDEC, 32'h8000_0000,  4'd10, 3'd3, 5'd16));
    pending_numbers.push_back(make_number(OP_SDEC, 32'h7FFF_FFFF,  4'd10, 3'd1, 5'd1));
    pending_numbers.push_back(make_number(OP_SDEC, 32'hFFFF_FFFF,  4'd3,  3'd2, 5'd4));
    pending_numbers.push_back(make_number(OP_SDEC, 32'd0,          4'd1,  3'd4, 5'd8));
    pending_numbers.push_back(make_number(OP_SDEC, -32'sd5,        4'd0,  3'd3, 5'd2));
    pending_numbers.push_back(make_number(OP_SDEC, 32'd123,        4'd15, 3'd5, 5'd3));
    pending_numbers.push_back(make_number(OP_SDEC, 32'h8000_0000,  4'd1,  3'd6, 5'd30));
    pending_numbers.push_back(make_number(OP_HEX,  32'hDEAD_BEEF,  4'd8,  3'd1, 5'd9));
    pending_numbers.push_back(make_number(OP_HEX,  32'hFFFF_FFFF,  4'd15, 3'd4, 5'd1));
    pending_numbers.push_back(make_number(OP_HEX,  32'd0,          4'd9,  3'd2, 5'd12));
    pending_numbers.push_back(make_number(OP_HEX,  32'hABCD_EF01,  4'd3,  3'd3, 5'd14));
    pending_numbers.push_back(make_number(OP_HEX,  32'd5,          4'd0,  3'd1, 5'd1));
    pending_numbers.push_back(make_number(OP_HEX,  32'h1234_5678,  4'd8,  3'd7, 5'd28));
    pending_numbers.push_back(make_number(OP_NONE, 32'hFFFF_FFFF,  4'd10, 3'd1, 5'd1));
    pending_numbers.push_back(make_number(OP_NONE, 32'd0,          4'd0,  3'd0, 5'd0));

    // Phase one: sender idles about a third of the time.
    sender_idle_pct = 32;
    queue_random_numbers(PHASE_ITEMS);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    drain();

    // Phase two: sender idles most of the time.
    sender_idle_pct = 60;
    queue_random_numbers(PHASE_ITEMS);
    drain();

    // Phase three: back-to-back numbers.
    sender_idle_pct = 0;
    queue_random_numbers(PHASE_ITEMS);
    drain();

    // Anything still expected here never came out.
    if (expected_chars.size() != 0) begin
      $error("characters missing: expected %0d more, got 0", expected_chars.size());
      error_count++;
    end

    $display("covered %0d unsigned, %0d signed, %0d hex and %0d ignored numbers",
             numbers_sent[OP_UDEC], numbers_sent[OP_SDEC], numbers_sent[OP_HEX],
             numbers_sent[OP_NONE]);
    $display("checked %0d characters over three sender idle rates", chars_checked);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fwnf_pkg.sv
sv/fwnf_ctrl.sv
sv/fwnf_dp.sv
sv/fixed_width_number_formatter.sv
sv/fwnf_checker.sv
verif/testbench.sv
